// ===== rtl/rvde_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and encodings for the RV32I decode/execute unit.
// No dependencies; imported by rvde_exec, the top level, the checker and the bench.
package rvde_pkg;

  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6f;
  localparam logic [6:0] OP_JALR   = 7'h67;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SRL  = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  localparam logic [2:0] F3_LB   = 3'd0;
  localparam logic [2:0] F3_LH   = 3'd1;
  localparam logic [2:0] F3_LW   = 3'd2;
  localparam logic [2:0] F3_LBU  = 3'd4;
  localparam logic [2:0] F3_LHU  = 3'd5;

  localparam logic [2:0] F3_SB   = 3'd0;
  localparam logic [2:0] F3_SH   = 3'd1;
  localparam logic [2:0] F3_SW   = 3'd2;

  localparam logic [2:0] F3_JALR = 3'd0;

  typedef struct packed {
    logic [31:0] instr_word;
    logic [15:0] instr_index;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] next_index;
    logic        taken;
    logic        reg_write;
    logic [4:0]  dest_reg;
    logic [31:0] dest_value;
    logic        illegal;
  } out_beat_t;

  typedef struct packed {
    logic [15:0] next_index;
    logic        taken;
    logic        wr;
    logic [4:0]  rd;
    logic [31:0] val;
    logic        illegal;
    logic        is_load;
    logic        is_store;
    logic [31:0] mem_sum;
    logic [31:0] store_data;
  } ex_result_t;

endpackage

// ===== rtl/rvde_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read.
// A read of the address written in the same cycle returns the new data.
module rvde_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata <= wdata;
      end else begin
        rdata <= mem[raddr];
      end
    end
  end

endmodule

// ===== rtl/rvde_exec.sv =====
`timescale 1ns / 1ps
// Decode and execute of one RV32I instruction: immediates, ALU, branch and
// jump targets, load/store address sum. Depends on rvde_pkg.
module rvde_exec (
  input  logic [31:0]          instr_word,
  input  logic [15:0]          instr_index,
  input  logic [31:0]          rs1_val,
  input  logic [31:0]          rs2_val,
  output rvde_pkg::ex_result_t res
);

  import rvde_pkg::*;

  logic [6:0]  op;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_j;
  logic [31:0] imm_u;
  logic [31:0] pc;
  logic [31:0] link;
  logic [31:0] br_sum;
  logic [31:0] jal_sum;
  logic [31:0] jalr_sum;
  logic [15:0] seq_index;
  logic [4:0]  sh_r;
  logic [4:0]  sh_i;
  logic        lt_s;
  logic        lt_u;
  logic        lt_si;
  logic        lt_ui;

  logic        v_wr;
  logic        v_taken;
  logic        v_bad;
  logic        v_load;
  logic        v_store;
  logic        v_cond;
  logic [31:0] v_val;
  logic [15:0] v_next;

  assign op    = instr_word[6:0];
  assign rd    = instr_word[11:7];
  assign f3    = instr_word[14:12];
  assign f7    = instr_word[31:25];
  assign imm_i = {{20{instr_word[31]}}, instr_word[31:20]};
  assign imm_s = {{20{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
  assign imm_b = {{19{instr_word[31]}}, instr_word[31], instr_word[7],
                  instr_word[30:25], instr_word[11:8], 1'b0};
  assign imm_j = {{11{instr_word[31]}}, instr_word[31], instr_word[19:12],
                  instr_word[20], instr_word[30:21], 1'b0};
  assign imm_u = {instr_word[31:12], 12'h000};

  assign pc        = {14'h0000, instr_index, 2'b00};
  assign link      = pc + 32'd4;
  assign br_sum    = pc + imm_b;
  assign jal_sum   = pc + imm_j;
  assign jalr_sum  = rs1_val + imm_i;
  assign seq_index = instr_index + 16'd1;
  assign sh_r      = rs2_val[4:0];
  assign sh_i      = instr_word[24:20];
  assign lt_s      = $signed(rs1_val) < $signed(rs2_val);
  assign lt_u      = rs1_val < rs2_val;
  assign lt_si     = $signed(rs1_val) < $signed(imm_i);
  assign lt_ui     = rs1_val < imm_i;

  always_comb begin
    v_wr    = 1'b0;
    v_taken = 1'b0;
    v_bad   = 1'b0;
    v_load  = 1'b0;
    v_store = 1'b0;
    v_cond  = 1'b0;
    v_val   = 32'h0;
    v_next  = seq_index;
    unique case (op)
      OP_REG: begin
        v_wr = 1'b1;
        if (f7 == F7_BASE) begin
          unique case (f3)
            F3_ADD:  v_val = rs1_val + rs2_val;
            F3_SLL:  v_val = rs1_val << sh_r;
            F3_SLT:  v_val = {31'h0, lt_s};
            F3_SLTU: v_val = {31'h0, lt_u};
            F3_XOR:  v_val = rs1_val ^ rs2_val;
            F3_SRL:  v_val = rs1_val >> sh_r;
            F3_OR:   v_val = rs1_val | rs2_val;
            F3_AND:  v_val = rs1_val & rs2_val;
          endcase
        end else if (f7 == F7_ALT && f3 == F3_ADD) begin
          v_val = rs1_val - rs2_val;
        end else if (f7 == F7_ALT && f3 == F3_SRL) begin
          v_val = 32'($signed(rs1_val) >>> sh_r);
        end else begin
          v_bad = 1'b1;
        end
      end
      OP_IMM: begin
        v_wr = 1'b1;
        unique case (f3)
          F3_ADD:  v_val = rs1_val + imm_i;
          F3_SLT:  v_val = {31'h0, lt_si};
          F3_SLTU: v_val = {31'h0, lt_ui};
          F3_XOR:  v_val = rs1_val ^ imm_i;
          F3_OR:   v_val = rs1_val | imm_i;
          F3_AND:  v_val = rs1_val & imm_i;
          F3_SLL: begin
            if (f7 == F7_BASE) begin
              v_val = rs1_val << sh_i;
            end else begin
              v_bad = 1'b1;
            end
          end
          F3_SRL: begin
            if (f7 == F7_BASE) begin
              v_val = rs1_val >> sh_i;
            end else if (f7 == F7_ALT) begin
              v_val = 32'($signed(rs1_val) >>> sh_i);
            end else begin
              v_bad = 1'b1;
            end
          end
        endcase
      end
      OP_LOAD: begin
        if (f3 == F3_LB || f3 == F3_LH || f3 == F3_LW || f3 == F3_LBU || f3 == F3_LHU) begin
          v_wr   = 1'b1;
          v_load = 1'b1;
        end else begin
          v_bad = 1'b1;
        end
      end
      OP_STORE: begin
        if (f3 == F3_SB || f3 == F3_SH || f3 == F3_SW) begin
          v_store = 1'b1;
        end else begin
          v_bad = 1'b1;
        end
      end
      OP_BRANCH: begin
        unique case (f3)
          F3_BEQ:  v_cond = (rs1_val == rs2_val);
          F3_BNE:  v_cond = (rs1_val != rs2_val);
          F3_BLT:  v_cond = lt_s;
          F3_BGE:  v_cond = !lt_s;
          F3_BLTU: v_cond = lt_u;
          F3_BGEU: v_cond = !lt_u;
          default: v_bad  = 1'b1;
        endcase
        if (v_cond) begin
          v_taken = 1'b1;
          v_next  = br_sum[17:2];
        end
      end
      OP_LUI: begin
        v_wr  = 1'b1;
        v_val = imm_u;
      end
      OP_AUIPC: begin
        v_wr  = 1'b1;
        v_val = pc + imm_u;
      end
      OP_JAL: begin
        v_wr    = 1'b1;
        v_val   = link;
        v_taken = 1'b1;
        v_next  = jal_sum[17:2];
      end
      OP_JALR: begin
        if (f3 == F3_JALR) begin
          v_wr    = 1'b1;
          v_val   = link;
          v_taken = 1'b1;
          v_next  = jalr_sum[17:2];
        end else begin
          v_bad = 1'b1;
        end
      end
      default: v_bad = 1'b1;
    endcase

    if (v_bad) begin
      v_wr    = 1'b0;
      v_taken = 1'b0;
      v_load  = 1'b0;
      v_store = 1'b0;
      v_next  = seq_index;
    end
    if (rd == 5'd0) begin
      v_wr = 1'b0;
    end

    res.next_index = v_next;
    res.taken      = v_taken;
    res.wr         = v_wr;
    res.rd         = v_wr ? rd : 5'd0;
    res.val        = (v_wr && !v_load) ? v_val : 32'h0;
    res.illegal    = v_bad;
    res.is_load    = v_load;
    res.is_store   = v_store;
    res.mem_sum    = rs1_val + (v_store ? imm_s : imm_i);
    res.store_data = rs2_val;
  end

endmodule

// ===== rtl/rvde_addr_reduce.sv =====
`timescale 1ns / 1ps
// Reduces a 32-bit byte-free word address modulo the data store depth.
// Per-byte residue tables, a four-way add and one parallel correction.
module rvde_addr_reduce #(
  parameter int MEM_DEPTH = 1024
) (
  input  logic [31:0]                  sum,
  output logic [$clog2(MEM_DEPTH)-1:0] addr
);

  localparam int AW = $clog2(MEM_DEPTH);
  localparam logic [AW+1:0] M1 = (AW + 2)'(MEM_DEPTH);
  localparam logic [AW+1:0] M2 = (AW + 2)'(2 * MEM_DEPTH);
  localparam logic [AW+1:0] M3 = (AW + 2)'(3 * MEM_DEPTH);

  logic [AW-1:0] res_tab [4][256];
  logic [AW-1:0] part    [4];
  logic [AW+1:0] total;
  logic [AW+1:0] red;

  for (genvar gi = 0; gi < 4; gi++) begin : g_byte
    localparam int unsigned WGT = (256 ** gi) % MEM_DEPTH;
    for (genvar gj = 0; gj < 256; gj++) begin : g_ent
      assign res_tab[gi][gj] = AW'((gj * WGT) % MEM_DEPTH);
    end
    assign part[gi] = res_tab[gi][sum[8*gi +: 8]];
  end

  assign total = {2'b00, part[0]} + {2'b00, part[1]} + {2'b00, part[2]} + {2'b00, part[3]};

  always_comb begin
    priority if (total >= M3) begin
      red = total - M3;
    end else if (total >= M2) begin
      red = total - M2;
    end else if (total >= M1) begin
      red = total - M1;
    end else begin
      red = total;
    end
  end

  assign addr = red[AW-1:0];

endmodule

// ===== rtl/rv32i_decode_execute_unit.sv =====
`timescale 1ns / 1ps
// RV32I decode/execute unit: register file and data store in RAM, three stages.
// Beats are registered in s1, s2 and s3 in turn; one beat per cycle while out_ready
// is high; an instruction reading the destination of the load just ahead waits in
// s1 while that load is in s2. Reset (rst_n low, synchronous) empties the pipeline;
// a clear pass then zeroes every data word with in_ready low. Depends on rvde_pkg.
module rv32i_decode_execute_unit #(
  parameter int MEM_DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rvde_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rvde_pkg::out_beat_t out_data
);

  import rvde_pkg::*;

  localparam int AW = $clog2(MEM_DEPTH);

  logic        in_fire;
  logic        out_fire;
  logic        adv2;
  logic        adv3;
  logic        s1_move;
  logic        s2_move;
  logic        stall;

  logic        s1_v_r;
  logic        s1_v_nxt;
  logic [31:0] s1_word_r;
  logic [15:0] s1_index_r;
  logic        s1_ok1_r;
  logic        s1_ok2_r;
  logic [4:0]  s1_rs1;
  logic [4:0]  s1_rs2;
  logic [31:0] op_a;
  logic [31:0] op_b;
  ex_result_t  ex_res;

  logic        s2_v_r;
  logic        s2_v_nxt;
  ex_result_t  s2_res_r;
  logic        s3_v_r;
  logic        s3_v_nxt;
  ex_result_t  s3_res_r;
  logic [31:0] s3_wb_val;

  logic [31:0] rf_valid_r;
  logic        rf_we;
  logic [31:0] rf_rd1;
  logic [31:0] rf_rd2;
  logic [4:0]  in_rs1;
  logic [4:0]  in_rs2;

  logic        lw_v_r;
  logic [4:0]  lw_rd_r;
  logic [31:0] lw_val_r;

  logic          clr_busy_r;
  logic          clr_busy_nxt;
  logic [AW-1:0] clr_addr_r;
  logic [AW-1:0] clr_addr_nxt;
  logic [AW-1:0] mem_addr;
  logic          dm_we;
  logic [AW-1:0] dm_addr;
  logic [31:0]   dm_wdata;
  logic          dm_re;
  logic [31:0]   dm_rdata;

  assign in_rs1 = in_data.instr_word[19:15];
  assign in_rs2 = in_data.instr_word[24:20];
  assign s1_rs1 = s1_word_r[19:15];
  assign s1_rs2 = s1_word_r[24:20];

  assign adv3     = !s3_v_r || out_ready;
  assign adv2     = !s2_v_r || adv3;
  assign s2_move  = s2_v_r && adv3;
  assign stall    = s2_v_r && s2_res_r.is_load && s2_res_r.wr &&
                    (s2_res_r.rd == s1_rs1 || s2_res_r.rd == s1_rs2);
  assign s1_move  = s1_v_r && adv2 && !stall;
  assign in_ready = !clr_busy_r && (!s1_v_r || s1_move);
  assign in_fire  = in_valid && in_ready;
  assign out_fire = s3_v_r && out_ready;

  assign s3_wb_val = (s3_res_r.is_load && s3_res_r.wr) ? dm_rdata : s3_res_r.val;
  assign rf_we     = out_fire && s3_res_r.wr;

  rvde_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (s3_res_r.rd),
    .wdata (s3_wb_val),
    .re    (in_fire),
    .raddr (in_rs1),
    .rdata (rf_rd1)
  );

  rvde_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (s3_res_r.rd),
    .wdata (s3_wb_val),
    .re    (in_fire),
    .raddr (in_rs2),
    .rdata (rf_rd2)
  );

  always_comb begin
    priority if (s2_v_r && s2_res_r.wr && s2_res_r.rd == s1_rs1) begin
      op_a = s2_res_r.val;
    end else if (s3_v_r && s3_res_r.wr && s3_res_r.rd == s1_rs1) begin
      op_a = s3_wb_val;
    end else if (lw_v_r && lw_rd_r == s1_rs1) begin
      op_a = lw_val_r;
    end else begin
      op_a = s1_ok1_r ? rf_rd1 : 32'h0;
    end
    priority if (s2_v_r && s2_res_r.wr && s2_res_r.rd == s1_rs2) begin
      op_b = s2_res_r.val;
    end else if (s3_v_r && s3_res_r.wr && s3_res_r.rd == s1_rs2) begin
      op_b = s3_wb_val;
    end else if (lw_v_r && lw_rd_r == s1_rs2) begin
      op_b = lw_val_r;
    end else begin
      op_b = s1_ok2_r ? rf_rd2 : 32'h0;
    end
  end

  rvde_exec u_exec (
    .instr_word  (s1_word_r),
    .instr_index (s1_index_r),
    .rs1_val     (op_a),
    .rs2_val     (op_b),
    .res         (ex_res)
  );

  rvde_addr_reduce #(.MEM_DEPTH(MEM_DEPTH)) u_addr (
    .sum  (s2_res_r.mem_sum),
    .addr (mem_addr)
  );

  assign dm_we    = clr_busy_r || (s2_move && s2_res_r.is_store);
  assign dm_addr  = clr_busy_r ? clr_addr_r : mem_addr;
  assign dm_wdata = clr_busy_r ? 32'h0 : s2_res_r.store_data;
  assign dm_re    = s2_move && s2_res_r.is_load;

  rvde_ram #(.WIDTH(32), .DEPTH(MEM_DEPTH)) u_dmem (
    .clk   (clk),
    .we    (dm_we),
    .waddr (dm_addr),
    .wdata (dm_wdata),
    .re    (dm_re),
    .raddr (dm_addr),
    .rdata (dm_rdata)
  );

  always_comb begin
    s1_v_nxt = in_fire ? 1'b1 : (s1_move ? 1'b0 : s1_v_r);
    s2_v_nxt = s1_move ? 1'b1 : (s2_move ? 1'b0 : s2_v_r);
    s3_v_nxt = s2_move ? 1'b1 : (out_fire ? 1'b0 : s3_v_r);
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      if (clr_addr_r == AW'(MEM_DEPTH - 1)) begin
        clr_busy_nxt = 1'b0;
      end else begin
        clr_addr_nxt = clr_addr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      s3_v_r     <= 1'b0;
      rf_valid_r <= 32'h0;
      lw_v_r     <= 1'b0;
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      s1_v_r     <= s1_v_nxt;
      s2_v_r     <= s2_v_nxt;
      s3_v_r     <= s3_v_nxt;
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
      if (rf_we) begin
        rf_valid_r[s3_res_r.rd] <= 1'b1;
        lw_v_r                  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_word_r  <= in_data.instr_word;
      s1_index_r <= in_data.instr_index;
      s1_ok1_r   <= rf_valid_r[in_rs1] || (rf_we && s3_res_r.rd == in_rs1);
      s1_ok2_r   <= rf_valid_r[in_rs2] || (rf_we && s3_res_r.rd == in_rs2);
    end
    if (s1_move) begin
      s2_res_r <= ex_res;
    end
    if (s2_move) begin
      s3_res_r <= s2_res_r;
    end
    if (rf_we) begin
      lw_rd_r  <= s3_res_r.rd;
      lw_val_r <= s3_wb_val;
    end
  end

  assign out_valid           = s3_v_r;
  assign out_data.next_index = s3_res_r.next_index;
  assign out_data.taken      = s3_res_r.taken;
  assign out_data.reg_write  = s3_res_r.wr;
  assign out_data.dest_reg   = s3_res_r.rd;
  assign out_data.dest_value = s3_wb_val;
  assign out_data.illegal    = s3_res_r.illegal;

endmodule

// ===== rtl/rvde_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the RV32I decode/execute unit, bound to the top level.
// Depends on rvde_pkg and rv32i_decode_execute_unit.
module rvde_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input rvde_pkg::out_beat_t out_data
);

  import rvde_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_illegal_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.illegal |->
      !out_data.taken && !out_data.reg_write && out_data.dest_value == 32'h0)
    else $error("illegal beat carries side effects");

  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.reg_write |->
      out_data.dest_reg == 5'd0 && out_data.dest_value == 32'h0)
    else $error("write-back fields set without write");

  a_write_not_x0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.reg_write |-> out_data.dest_reg != 5'd0)
    else $error("write-back to x0");

endmodule

bind rv32i_decode_execute_unit rvde_checker u_rvde_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== bench/tb_rv32i_decode_execute_unit.sv =====
`timescale 1ns / 1ps
// Self-checking bench for rv32i_decode_execute_unit: directed and random RV32I streams,
// each result beat compared against an in-bench execute model. Depends on rvde_pkg.
module tb_rv32i_decode_execute_unit;
  import rvde_pkg::*;

  localparam int unsigned MEM_DEPTH   = 1024;
  localparam int unsigned AW          = $clog2(MEM_DEPTH);
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;

  localparam logic [6:0] F7_MULDIV      = 7'h01;
  localparam logic [6:0] F7_RSVD        = 7'h10;
  localparam logic [2:0] F3_LOAD_RSVD   = 3'd3;
  localparam logic [2:0] F3_STORE_RSVD  = 3'd7;
  localparam logic [2:0] F3_BRANCH_RSVD = 3'd2;
  localparam logic [2:0] F3_JALR_RSVD   = 3'd1;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_data;

  logic [31:0] gpr [32];
  logic [31:0] dmem [MEM_DEPTH];
  out_beat_t   retire_queue [$];
  out_beat_t   head_result;
  int          mismatches = 0;
  int          send_gap_pct = 0;
  int          sink_stall_pct = 0;
  int unsigned cycle_count = 0;

  rv32i_decode_execute_unit #(.MEM_DEPTH(MEM_DEPTH)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic out_beat_t execute_instr(input in_beat_t beat);
    logic [31:0] w, a, bv, pc, val, sum;
    logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u;
    logic [6:0]  op, f7;
    logic [4:0]  rd, sh;
    logic [2:0]  f3;
    logic [15:0] nxt;
    logic        wr, redirect, bad;
    out_beat_t   r;
    w     = beat.instr_word;
    op    = w[6:0];
    rd    = w[11:7];
    f3    = w[14:12];
    f7    = w[31:25];
    a     = gpr[w[19:15]];
    bv    = gpr[w[24:20]];
    pc    = {14'd0, beat.instr_index, 2'b00};
    imm_i = {{20{w[31]}}, w[31:20]};
    imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
    imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    imm_u = {w[31:12], 12'd0};
    nxt      = beat.instr_index + 16'd1;
    val      = '0;
    wr       = 1'b0;
    redirect = 1'b0;
    bad      = 1'b0;
    case (op)
      OP_REG: begin
        sh = bv[4:0];
        wr = 1'b1;
        if (f7 == F7_BASE) begin
          case (f3)
            F3_ADD:  val = a + bv;
            F3_SLL:  val = a << sh;
            F3_SLT:  val = {31'd0, ($signed(a) < $signed(bv))};
            F3_SLTU: val = {31'd0, (a < bv)};
            F3_XOR:  val = a ^ bv;
            F3_SRL:  val = a >> sh;
            F3_OR:   val = a | bv;
            F3_AND:  val = a & bv;
          endcase
        end else if (f7 == F7_ALT && f3 == F3_ADD) begin
          val = a - bv;
        end else if (f7 == F7_ALT && f3 == F3_SRL) begin
          val = $signed(a) >>> sh;
        end else begin
          bad = 1'b1;
        end
      end
      OP_IMM: begin
        sh = imm_i[4:0];
        wr = 1'b1;
        case (f3)
          F3_ADD:  val = a + imm_i;
          F3_SLT:  val = {31'd0, ($signed(a) < $signed(imm_i))};
          F3_SLTU: val = {31'd0, (a < imm_i)};
          F3_XOR:  val = a ^ imm_i;
          F3_OR:   val = a | imm_i;
          F3_AND:  val = a & imm_i;
          F3_SLL: begin
            if (f7 == F7_BASE) val = a << sh;
            else bad = 1'b1;
          end
          F3_SRL: begin
            if (f7 == F7_BASE) val = a >> sh;
            else if (f7 == F7_ALT) val = $signed(a) >>> sh;
            else bad = 1'b1;
          end
        endcase
      end
      OP_LOAD: begin
        case (f3)
          F3_LB, F3_LH, F3_LW, F3_LBU, F3_LHU: begin
            wr  = 1'b1;
            sum = a + imm_i;
            val = dmem[AW'(sum % MEM_DEPTH)];
          end
          default: bad = 1'b1;
        endcase
      end
      OP_STORE: begin
        case (f3)
          F3_SB, F3_SH, F3_SW: begin
            sum = a + imm_s;
            dmem[AW'(sum % MEM_DEPTH)] = bv;
          end
          default: bad = 1'b1;
        endcase
      end
      OP_BRANCH: begin
        case (f3)
          F3_BEQ:  redirect = (a == bv);
          F3_BNE:  redirect = (a != bv);
          F3_BLT:  redirect = ($signed(a) < $signed(bv));
          F3_BGE:  redirect = !($signed(a) < $signed(bv));
          F3_BLTU: redirect = (a < bv);
          F3_BGEU: redirect = (a >= bv);
          default: bad = 1'b1;
        endcase
        if (redirect) begin
          sum = pc + imm_b;
          nxt = sum[17:2];
        end
      end
      OP_LUI: begin
        wr  = 1'b1;
        val = imm_u;
      end
      OP_AUIPC: begin
        wr  = 1'b1;
        val = pc + imm_u;
      end
      OP_JAL: begin
        wr       = 1'b1;
        val      = pc + 32'd4;
        redirect = 1'b1;
        sum      = pc + imm_j;
        nxt      = sum[17:2];
      end
      OP_JALR: begin
        if (f3 != F3_JALR) begin
          bad = 1'b1;
        end else begin
          wr       = 1'b1;
          val      = pc + 32'd4;
          redirect = 1'b1;
          sum      = a + imm_i;
          nxt      = sum[17:2];
        end
      end
      default: bad = 1'b1;
    endcase
    if (bad) begin
      wr       = 1'b0;
      redirect = 1'b0;
      val      = '0;
      nxt      = beat.instr_index + 16'd1;
    end
    if (rd == 5'd0) wr = 1'b0;
    if (wr) begin
      gpr[rd] = val;
    end else begin
      rd  = '0;
      val = '0;
    end
    r.next_index = nxt;
    r.taken      = redirect;
    r.reg_write  = wr;
    r.dest_reg   = rd;
    r.dest_value = val;
    r.illegal    = bad;
    return r;
  endfunction

  function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2, rs1,
                                        input logic [2:0] f3, input logic [4:0] rd);
    return {f7, rs2, rs1, f3, rd, OP_REG};
  endfunction

  function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
                                        input logic [2:0] f3, input logic [4:0] rd,
                                        input logic [6:0] op);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_s(input logic [11:0] imm, input logic [4:0] rs2, rs1,
                                        input logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
  endfunction

  function automatic logic [31:0] enc_b(input logic [12:0] imm, input logic [4:0] rs2, rs1,
                                        input logic [2:0] f3);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
  endfunction

  function automatic logic [31:0] enc_u(input logic [19:0] imm, input logic [4:0] rd,
                                        input logic [6:0] op);
    return {imm, rd, op};
  endfunction

  function automatic logic [31:0] enc_j(input logic [20:0] imm, input logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
  endfunction

  // favor a few registers so back-to-back dependences show up often
  function automatic logic [4:0] pick_reg();
    return $urandom_range(1) ? 5'($urandom_range(7)) : 5'($urandom);
  endfunction

  function automatic logic [31:0] random_instr();
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [11:0] imm;
    logic [31:0] w;
    int unsigned pick;
    rd   = pick_reg();
    rs1  = pick_reg();
    rs2  = pick_reg();
    imm  = 12'($urandom);
    pick = $urandom_range(99);
    if (pick < 20) begin
      f3 = 3'($urandom_range(7));
      if ($urandom_range(3) == 0) begin
        f3 = $urandom_range(1) ? F3_ADD : F3_SRL;
        w  = enc_r(F7_ALT, rs2, rs1, f3, rd);
      end else begin
        w = enc_r(F7_BASE, rs2, rs1, f3, rd);
      end
    end else if (pick < 42) begin
      f3 = 3'($urandom_range(7));
      if (f3 == F3_SLL) imm[11:5] = F7_BASE;
      if (f3 == F3_SRL) imm[11:5] = $urandom_range(1) ? F7_ALT : F7_BASE;
      w = enc_i(imm, rs1, f3, rd, OP_IMM);
    end else if (pick < 56) begin
      do f3 = 3'($urandom_range(7));
      while (!(f3 inside {F3_LB, F3_LH, F3_LW, F3_LBU, F3_LHU}));
      if ($urandom_range(1)) begin
        rs1 = '0;
        imm = 12'($urandom_range(15));
      end
      w = enc_i(imm, rs1, f3, rd, OP_LOAD);
    end else if (pick < 68) begin
      f3 = 3'($urandom_range(F3_SW));
      if ($urandom_range(1)) begin
        rs1 = '0;
        imm = 12'($urandom_range(15));
      end
      w = enc_s(imm, rs2, rs1, f3);
    end else if (pick < 80) begin
      do f3 = 3'($urandom_range(7));
      while (!(f3 inside {F3_BEQ, F3_BNE, F3_BLT, F3_BGE, F3_BLTU, F3_BGEU}));
      w = enc_b(13'($urandom), rs2, rs1, f3);
    end else if (pick < 85) begin
      w = enc_u(20'($urandom), rd, OP_LUI);
    end else if (pick < 89) begin
      w = enc_u(20'($urandom), rd, OP_AUIPC);
    end else if (pick < 93) begin
      w = enc_j(21'($urandom), rd);
    end else begin
      w = enc_i(imm, rs1, F3_JALR, rd, OP_JALR);
    end
    // scramble everything above the opcode, or the whole word
    if ($urandom_range(99) < 8) w[31:7] = 25'($urandom);
    else if ($urandom_range(99) < 3) w = $urandom;
    return w;
  endfunction

  task automatic issue_instr(input logic [31:0] word, input logic [15:0] idx);
    in_beat_t beat;
    beat.instr_word  = word;
    beat.instr_index = idx;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    retire_queue.insert(retire_queue.size(), execute_instr(beat));
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (retire_queue.size() == 0) begin
        $error("result beat with no instruction pending: %h", out_data);
        mismatches++;
      end else begin
        head_result = retire_queue.pop_front();
        check_field("next_index", 32'(head_result.next_index), 32'(out_data.next_index));
        check_field("taken", 32'(head_result.taken), 32'(out_data.taken));
        check_field("reg_write", 32'(head_result.reg_write), 32'(out_data.reg_write));
        check_field("dest_reg", 32'(head_result.dest_reg), 32'(out_data.dest_reg));
        check_field("dest_value", head_result.dest_value, out_data.dest_value);
        check_field("illegal", 32'(head_result.illegal), 32'(out_data.illegal));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_rv32i_decode_execute_unit failed");
      $finish;
    end
  end

  task automatic test_alu_extremes();
    issue_instr(enc_u(20'hfffff, 5'd1, OP_LUI), 16'h0000);
    issue_instr(enc_i(12'hfff, 5'd0, F3_ADD, 5'd2, OP_IMM), 16'h0001);
    issue_instr(enc_i(12'h7ff, 5'd0, F3_ADD, 5'd3, OP_IMM), 16'h0002);
    issue_instr(enc_u(20'h80000, 5'd4, OP_LUI), 16'h0003);
    issue_instr(enc_r(F7_ALT, 5'd4, 5'd0, F3_ADD, 5'd5), 16'h0004);
    issue_instr(enc_r(F7_ALT, 5'd2, 5'd4, F3_SRL, 5'd6), 16'h0005);
    issue_instr(enc_i({F7_ALT, 5'd31}, 5'd4, F3_SRL, 5'd7, OP_IMM), 16'h0006);
    issue_instr(enc_r(F7_BASE, 5'd3, 5'd4, F3_SLT, 5'd9), 16'h0007);
    issue_instr(enc_r(F7_BASE, 5'd2, 5'd2, F3_ADD, 5'd0), 16'h0008);
    issue_instr(enc_u(20'hfffff, 5'd11, OP_AUIPC), 16'hffff);
  endtask

  task automatic test_data_store();
    issue_instr(enc_s(12'hfff, 5'd4, 5'd0, F3_SB), 16'h0100);
    issue_instr(enc_i(12'h800, 5'd3, F3_LHU, 5'd12, OP_LOAD), 16'h0101);
    issue_instr(enc_s(12'h7ff, 5'd2, 5'd2, F3_SW), 16'h0102);
    issue_instr(enc_i(12'h3fe, 5'd0, F3_LB, 5'd13, OP_LOAD), 16'h0103);
    issue_instr(enc_r(F7_BASE, 5'd13, 5'd13, F3_ADD, 5'd14), 16'h0104);
  endtask

  task automatic test_control_flow();
    issue_instr(enc_b(13'h1000, 5'd0, 5'd0, F3_BEQ), 16'h0000);
    issue_instr(enc_b(13'h0006, 5'd4, 5'd3, F3_BLTU), 16'h0005);
    issue_instr(enc_b(13'h0ffe, 5'd3, 5'd4, F3_BGE), 16'h0009);
    issue_instr(enc_j(21'h0ffffe, 5'd1), 16'hffff);
    issue_instr(enc_j(21'h100000, 5'd0), 16'h0000);
    issue_instr(enc_i(12'h000, 5'd2, F3_JALR, 5'd2, OP_JALR), 16'h1234);
  endtask

  task automatic test_illegal_encodings();
    issue_instr(32'h0000_0000, 16'h0010);
    issue_instr(32'hffff_ffff, 16'h0011);
    issue_instr(enc_r(F7_MULDIV, 5'd2, 5'd4, F3_ADD, 5'd15), 16'h0012);
    issue_instr(enc_i({F7_RSVD, 5'd3}, 5'd4, F3_SRL, 5'd16, OP_IMM), 16'h0013);
    issue_instr(enc_i(12'h3ff, 5'd0, F3_LOAD_RSVD, 5'd17, OP_LOAD), 16'h0014);
    issue_instr(enc_s(12'h3ff, 5'd2, 5'd0, F3_STORE_RSVD), 16'h0015);
    issue_instr(enc_b(13'h0008, 5'd0, 5'd0, F3_BRANCH_RSVD), 16'h0016);
    issue_instr(enc_i(12'h010, 5'd0, F3_JALR_RSVD, 5'd18, OP_JALR), 16'hffff);
  endtask

  task automatic test_random_mix(input int count, input int send_pct, input int sink_pct);
    send_gap_pct   = send_pct;
    sink_stall_pct = sink_pct;
    repeat (count) issue_instr(random_instr(), 16'($urandom));
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    foreach (gpr[i]) gpr[i] = '0;
    foreach (dmem[i]) dmem[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_alu_extremes();
    test_data_store();
    test_control_flow();
    test_illegal_encodings();
    test_random_mix(300, 22, 63);
    test_random_mix(300, 63, 22);
    test_random_mix(300, 0, 0);
    in_valid <= 1'b0;
    while (retire_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_rv32i_decode_execute_unit passed");
    end else begin
      $display("tb_rv32i_decode_execute_unit failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rvde_pkg.sv
rtl/rvde_ram.sv
rtl/rvde_exec.sv
rtl/rvde_addr_reduce.sv
rtl/rv32i_decode_execute_unit.sv
rtl/rvde_checker.sv
bench/tb_rv32i_decode_execute_unit.sv
